// File: src/scpe_pkg.sv
`default_nettype none

package scpe_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
    localparam logic [1:0] REG_CURVE_MODE = 2'd1;
    localparam logic [1:0] REG_GAIN       = 2'd2;

    // Curve modes (code three behaves as absolute sine)
    localparam logic [1:0] MODE_ABS    = 2'd0;
    localparam logic [1:0] MODE_RAISED = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;

    localparam logic [12:0] RST_TABLE_SIZE = 13'd256;
    localparam logic [1:0]  RST_CURVE_MODE = MODE_ABS;
    localparam logic [15:0] RST_GAIN       = 16'd16384;

    localparam logic [12:0] MAX_ENTRIES = 13'd4096;
    localparam int unsigned DEF_SINE_TABLE_DEPTH = 1024;

    // Channel phase offsets, 2^32 is a full turn
    localparam logic [31:0] OFFSET_RED   = 32'd0;
    localparam logic [31:0] OFFSET_GREEN = 32'd715827883;
    localparam logic [31:0] OFFSET_BLUE  = 32'd1431655765;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [17:0] ONE_Q16     = 18'd65536;
    localparam logic [15:0] ALPHA_HALF  = 16'd32768;

    // Quotient pipeline: 32 quotient bits, four per stage
    localparam int unsigned QUO_BITS       = 32;
    localparam int unsigned DIV_BITS_STAGE = 4;
    localparam int unsigned DIV_STAGES     = QUO_BITS / DIV_BITS_STAGE;

    // Channel pipeline: phase, angle, address, rom, gain product, saturate
    localparam int unsigned CH_STAGES = 6;

    // Sampled latency from accept edge to strobe
    localparam int unsigned LATENCY = 1 + DIV_STAGES + CH_STAGES;

    typedef struct packed {
        logic double_angle;
        logic raised;
    } t_curve;

endpackage

`default_nettype wire

// File: src/scpe_divider.sv
`default_nettype none

// floor(idx * 2^32 / n), restoring division, DIV_BITS_STAGE quotient bits per stage
module scpe_divider import scpe_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_vld,
    input  wire logic [11:0]         i_idx,
    input  wire logic [12:0]         i_n,
    output logic                     o_vld,
    output logic [QUO_BITS-1:0]      o_quo
);

    logic [12:0]         r_rem [DIV_STAGES];
    logic [QUO_BITS-1:0] r_quo [DIV_STAGES];
    logic                r_vld [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [12:0]         in_rem;
        logic [QUO_BITS-1:0] in_quo;
        logic                in_vld;
        logic [12:0]         n_rem;
        logic [QUO_BITS-1:0] n_quo;
        logic [13:0]         t;

        if (s == 0) begin : g_first
            // idx < n, so the integer part of the quotient is zero and idx is the remainder
            assign in_rem = {1'b0, i_idx};
            assign in_quo = '0;
            assign in_vld = i_vld;
        end else begin : g_next
            assign in_rem = r_rem[s-1];
            assign in_quo = r_quo[s-1];
            assign in_vld = r_vld[s-1];
        end

        always_comb begin
            n_rem = in_rem;
            n_quo = in_quo;
            t     = '0;
            for (int k = 0; k < DIV_BITS_STAGE; k++) begin
                t = {n_rem, 1'b0};
                if (t >= {1'b0, i_n}) begin
                    n_rem = 13'(t - {1'b0, i_n});
                    n_quo = {n_quo[QUO_BITS-2:0], 1'b1};
                end else begin
                    n_rem = t[12:0];
                    n_quo = {n_quo[QUO_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_quo[s] <= n_quo;
        end
    end

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: src/scpe_sine_rom.sv
`default_nettype none

// Quarter-wave sine, DEPTH+1 entries of Q1.16, registered read
module scpe_sine_rom import scpe_pkg::*; #(
    parameter int unsigned DEPTH = DEF_SINE_TABLE_DEPTH,
    localparam int unsigned AW   = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic [AW-1:0] i_addr,
    output logic [16:0]        o_data
);

    // Taylor series to x^15 in Q30, rounded to Q16
    function automatic logic [16:0] sine_entry(input int unsigned j);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (64'(j) * HALF_PI_Q30) / 64'(DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - signed'(term);
        if (sum < 0) begin
            sum = '0;
        end
        v = (unsigned'(sum) + 64'd8192) >> 14;
        if (v > 64'd65536) begin
            v = 64'd65536;
        end
        return v[16:0];
    endfunction

    logic [16:0] rom [DEPTH+1];

    for (genvar g = 0; g <= DEPTH; g++) begin : g_entry
        localparam logic [16:0] ENTRY = sine_entry(g);
        assign rom[g] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        o_data <= rom[i_addr];
    end

endmodule

`default_nettype wire

// File: src/scpe_channel.sv
`default_nettype none

// One colour channel: phase -> quarter-wave lookup -> curve -> gain -> saturate
module scpe_channel import scpe_pkg::*; #(
    parameter int unsigned SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
    parameter logic [31:0] OFFSET           = OFFSET_RED
) (
    input  wire logic        i_clk,
    input  wire logic [30:0] i_step,
    input  wire t_curve      i_curve,
    input  wire logic [15:0] i_gain,
    output logic [15:0]      o_value
);

    localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH + 1);

    logic [31:0]   n_phase;
    logic [31:0]   r_phase;
    logic [45:0]   w_angle;
    logic [AW-1:0] r_a;
    logic [1:0]    r_quad;
    logic [AW-1:0] r_addr;
    logic          r_neg_a;
    logic          r_neg_m;
    logic [16:0]   w_mag;
    logic [17:0]   w_sum;
    logic [16:0]   w_curve_val;
    logic [32:0]   r_prod;
    logic [18:0]   w_scaled;

    always_comb begin
        n_phase = OFFSET + {1'b0, i_step};
        if (i_curve.double_angle) begin
            n_phase = {n_phase[30:0], 1'b0};
        end
    end

    // round(r * D / 2^30) for the low 30 phase bits
    assign w_angle = 46'(r_phase[29:0]) * 46'(SINE_TABLE_DEPTH) + (46'd1 << 29);

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_a     <= w_angle[30 +: AW];
        r_quad  <= r_phase[31:30];
        r_addr  <= r_quad[0] ? AW'(SINE_TABLE_DEPTH) - r_a : r_a;
        r_neg_a <= r_quad[1];
        r_neg_m <= r_neg_a;
    end

    scpe_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_addr),
        .o_data (w_mag)
    );

    always_comb begin
        w_sum = r_neg_m ? ONE_Q16 - 18'(w_mag) : ONE_Q16 + 18'(w_mag);
        if (i_curve.raised) begin
            w_curve_val = w_sum[17:1];
        end else begin
            w_curve_val = w_mag;
        end
    end

    assign w_scaled = r_prod[32:14];

    always_ff @(posedge i_clk) begin
        r_prod  <= 33'(w_curve_val) * 33'(i_gain);
        o_value <= (|w_scaled[18:16]) ? 16'hFFFF : w_scaled[15:0];
    end

endmodule

`default_nettype wire

// File: src/sine_colour_palette_entry_top.sv
`default_nettype none

// Sinusoidal RGB palette entry generator. One index is taken per clock (busy is low
// whenever reset is released) and its colour comes out as a one-cycle o_strobe; the
// receiver cannot stall. The result passes through the clamped-index input register,
// the 8-stage index/table_size quotient pipeline (4 quotient bits per stage) and 6
// channel stages: phase, angle scaling, rom address, registered quarter-wave rom read,
// gain multiply and saturation. Each channel has its own copy of the
// SINE_TABLE_DEPTH+1 entry rom. Registers are written through the cfg port and must
// only change while no transaction is in flight; o_alpha is always one half.
module sine_colour_palette_entry_top import scpe_pkg::*; #(
    parameter int unsigned SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [11:0] i_index,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_strobe,
    output logic [15:0]      o_red,
    output logic [15:0]      o_green,
    output logic [15:0]      o_blue,
    output logic [15:0]      o_alpha
);

    logic [12:0]          r_table_size;
    logic [1:0]           r_curve_mode;
    logic [15:0]          r_gain;
    logic [12:0]          w_n;
    logic                 w_accept;
    logic                 r_in_vld;
    logic [11:0]          r_in_idx;
    logic                 w_div_vld;
    logic [QUO_BITS-1:0]  w_quo;
    logic [30:0]          w_step;
    t_curve               w_curve;
    logic [CH_STAGES-1:0] r_vld_dly;

    assign busy        = !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= RST_TABLE_SIZE;
            r_curve_mode <= RST_CURVE_MODE;
            r_gain       <= RST_GAIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TABLE_SIZE: r_table_size <= i_cfg_data[12:0];
                REG_CURVE_MODE: r_curve_mode <= i_cfg_data[1:0];
                REG_GAIN:       r_gain       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_table_size == '0) begin
            w_n = 13'd1;
        end else if (r_table_size > MAX_ENTRIES) begin
            w_n = MAX_ENTRIES;
        end else begin
            w_n = r_table_size;
        end
    end

    assign w_curve.double_angle = (r_curve_mode == MODE_DOUBLE);
    assign w_curve.raised       = (r_curve_mode == MODE_RAISED) ||
                                  (r_curve_mode == MODE_DOUBLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= w_accept;
        end
    end

    // clamp past-the-end indexes to the last entry
    always_ff @(posedge i_clk) begin
        r_in_idx <= ({1'b0, i_index} >= w_n) ? 12'(w_n - 13'd1) : i_index;
    end

    scpe_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_idx   (r_in_idx),
        .i_n     (w_n),
        .o_vld   (w_div_vld),
        .o_quo   (w_quo)
    );

    // floor(idx * 2^31 / n)
    assign w_step = w_quo[QUO_BITS-1:1];

    scpe_channel #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .OFFSET           (OFFSET_RED)
    ) u_red (
        .i_clk   (i_clk),
        .i_step  (w_step),
        .i_curve (w_curve),
        .i_gain  (r_gain),
        .o_value (o_red)
    );

    scpe_channel #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .OFFSET           (OFFSET_GREEN)
    ) u_green (
        .i_clk   (i_clk),
        .i_step  (w_step),
        .i_curve (w_curve),
        .i_gain  (r_gain),
        .o_value (o_green)
    );

    scpe_channel #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .OFFSET           (OFFSET_BLUE)
    ) u_blue (
        .i_clk   (i_clk),
        .i_step  (w_step),
        .i_curve (w_curve),
        .i_gain  (r_gain),
        .o_value (o_blue)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_dly <= '0;
        end else begin
            r_vld_dly <= {r_vld_dly[CH_STAGES-2:0], w_div_vld};
        end
    end

    assign o_strobe = r_vld_dly[CH_STAGES-1];
    assign o_alpha  = ALPHA_HALF;

endmodule

`default_nettype wire

// File: src/scpe_checker.sv
`default_nettype none

module scpe_checker import scpe_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [11:0] i_index,
    input wire logic        o_strobe,
    input wire logic [15:0] o_red,
    input wire logic [15:0] o_green,
    input wire logic [15:0] o_blue,
    input wire logic [15:0] o_alpha
);

    // every accepted transaction gives a strobe after the fixed latency
    a_accept_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("accepted transaction produced no result");

    // no strobe without a matching accept
    a_strobe_has_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && i_rst_n, LATENCY))
        else $error("result without accepted transaction");

    // back-to-back transactions with the same index give the same colour
    a_same_index_same_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe) &&
         ($past(i_index, LATENCY) == $past(i_index, LATENCY + 1)))
        |-> (o_red == $past(o_red) && o_green == $past(o_green) &&
             o_blue == $past(o_blue)))
        else $error("same index gave different colours");

    a_alpha_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_alpha == ALPHA_HALF))
        else $error("alpha is not one half");

endmodule

bind sine_colour_palette_entry_top scpe_checker u_scpe_checker (.*);

`default_nettype wire
